[design/frem_pkg.sv]
// shared types and constants for the binary32 remainder block
`timescale 1ns / 1ps
`default_nettype none
package frem_pkg;
    localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
    localparam logic [31:0] ABS_MASK   = 32'h7fff_ffff;
    localparam logic [31:0] EXP_ALL    = 32'h7f80_0000;
    localparam logic [31:0] HIDDEN_BIT = 32'h0080_0000;
    localparam logic [31:0] FRAC_MASK  = 32'h007f_ffff;
    localparam logic [31:0] QNAN_BITS  = 32'h7fc0_0000;
    localparam int          MIN_EXP    = -126;
    localparam int          EXP_BIAS   = 127;
    localparam int          QDEPTH     = 2;

    // front decision for one word
    localparam logic [1:0] KIND_DIRECT = 2'd0;
    localparam logic [1:0] KIND_LOOP   = 2'd1;

    // classified job handed from front to back
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] direct;
        logic        sign;
        logic [9:0]  ex;      // signed unbiased exponent of dividend
        logic [9:0]  ey;      // signed unbiased exponent of divisor
        logic [31:0] mx;      // raw magnitudes, normalized in back end
        logic [31:0] my;
    } job_t;
endpackage
`default_nettype wire

[design/frem_front.sv]
// front end: classify operands and push jobs into a small queue
`timescale 1ns / 1ps
`default_nettype none
module frem_front import frem_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] dividend_bits,
    input  wire logic [31:0] divisor_bits,
    output logic             job_valid,
    input  wire logic        job_take,
    output job_t             job
);
    job_t       q_reg [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic [31:0] ax, ay;
    job_t       nj;

    assign ax = dividend_bits & ABS_MASK;
    assign ay = divisor_bits & ABS_MASK;

    // special cases and raw exponents
    always_comb
    begin
        nj = '0;
        nj.sign = dividend_bits[31];
        nj.mx = ax;
        nj.my = ay;
        nj.ex = (ax >= HIDDEN_BIT) ? 10'({2'b0, ax[30:23]} - 10'(EXP_BIAS)) : 10'(MIN_EXP);
        nj.ey = (ay >= HIDDEN_BIT) ? 10'({2'b0, ay[30:23]} - 10'(EXP_BIAS)) : 10'(MIN_EXP);
        nj.kind = KIND_DIRECT;
        if (ay == 32'd0 || ax >= EXP_ALL || ay > EXP_ALL)
            nj.direct = QNAN_BITS;
        else if (ax < ay)
            nj.direct = dividend_bits;
        else if (ax == ay)
            nj.direct = dividend_bits & SIGN_MASK;
        else
            nj.kind = KIND_LOOP;
    end

    assign in_stall  = (cnt_reg == 2'(QDEPTH));
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rp_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            q_reg[wp_reg] <= nj;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
                wp_reg <= ~wp_reg;
            if (job_take && job_valid)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(in_valid && !in_stall) - 2'(job_take && job_valid);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QDEPTH)) else $error("queue overflow");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'(QDEPTH)) |-> in_stall) else $error("full without stall");
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !job_valid) else $error("empty queue valid");
endmodule
`default_nettype wire

[design/frem_back.sv]
// back end: normalize, shift-subtract loop, renormalize, pack
`timescale 1ns / 1ps
`default_nettype none
module frem_back import frem_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        job_valid,
    output logic             job_take,
    input  job_t             job,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      remainder_bits
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NORM = 3'd1;
    localparam logic [2:0] S_LOOP = 3'd2;
    localparam logic [2:0] S_REN  = 3'd3;
    localparam logic [2:0] S_SUB  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  st_reg, st_next;
    logic [24:0] mx_reg, mx_next;
    logic [23:0] my_reg, my_next;
    logic [9:0]  ex_reg, ex_next, ey_reg, ey_next;
    logic [8:0]  steps_reg, steps_next;
    logic        sign_reg, sign_next;
    logic [31:0] res_reg, res_next;
    logic        ov_reg, ov_next;
    logic [9:0]  sh;
    logic [31:0] packed_w;

    // result packing, with a right shift for subnormal results
    always_comb
    begin
        sh = 10'(MIN_EXP) - ey_reg;
        if (!ey_reg[9] || $signed(ey_reg) >= MIN_EXP)
            packed_w = {sign_reg, 8'(ey_reg + 10'(EXP_BIAS)), mx_reg[22:0]};
        else if ($signed(sh) > 31)
            packed_w = {sign_reg, 31'd0};
        else
            packed_w = {sign_reg, 31'(32'(mx_reg[23:0]) >> sh[4:0])};
    end

    assign job_take       = (st_reg == S_IDLE) && (!ov_reg || !out_stall);
    assign out_valid      = ov_reg;
    assign remainder_bits = res_reg;

    // sequencer
    always_comb
    begin
        st_next = st_reg; mx_next = mx_reg; my_next = my_reg;
        ex_next = ex_reg; ey_next = ey_reg; steps_next = steps_reg;
        sign_next = sign_reg; res_next = res_reg;
        ov_next = ov_reg && out_stall;
        unique case (st_reg)
            S_IDLE:
            begin
                if (job_valid && job_take)
                begin
                    sign_next = job.sign;
                    if (job.kind == KIND_DIRECT)
                    begin
                        res_next = job.direct;
                        ov_next = 1'b1;
                    end
                    else
                    begin
                        mx_next = {1'b0, (job.mx >= HIDDEN_BIT), job.mx[22:0]};
                        my_next = {(job.my >= HIDDEN_BIT), job.my[22:0]};
                        ex_next = job.ex; ey_next = job.ey;
                        st_next = S_NORM;
                    end
                end
            end
            S_NORM:
            begin
                // one left shift a cycle for subnormal operands
                if (!mx_reg[23])
                begin
                    mx_next = {mx_reg[23:0], 1'b0}; ex_next = ex_reg - 10'd1;
                end
                else if (!my_reg[23])
                begin
                    my_next = {my_reg[22:0], 1'b0}; ey_next = ey_reg - 10'd1;
                end
                else
                begin
                    steps_next = 9'(ex_reg - ey_reg);
                    st_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (steps_reg == 9'd0)
                    st_next = S_SUB;
                else if (mx_reg < {1'b0, my_reg})
                begin
                    mx_next = {mx_reg[23:0], 1'b0}; steps_next = steps_reg - 9'd1;
                end
                else if (mx_reg == {1'b0, my_reg})
                begin
                    res_next = {sign_reg, 31'd0}; st_next = S_OUT;
                end
                else
                begin
                    mx_next = {mx_reg[23:0] - my_reg, 1'b0};
                    steps_next = steps_reg - 9'd1;
                end
            end
            S_SUB:
            begin
                mx_next = (mx_reg >= {1'b0, my_reg}) ? mx_reg - {1'b0, my_reg} : mx_reg;
                if (mx_next == 25'd0)
                begin
                    res_next = {sign_reg, 31'd0}; st_next = S_OUT;
                end
                else
                    st_next = S_REN;
            end
            S_REN:
            begin
                if (!mx_reg[23])
                begin
                    mx_next = {mx_reg[23:0], 1'b0}; ey_next = ey_reg - 10'd1;
                end
                else
                begin
                    res_next = packed_w; st_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1; st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mx_reg <= mx_next; my_reg <= my_next;
        ex_reg <= ex_next; ey_reg <= ey_next;
        steps_reg <= steps_next; sign_reg <= sign_next; res_reg <= res_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> $stable(res_reg)) else $error("result changed");
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_LOOP) |-> (mx_reg < {my_reg, 1'b0})) else $error("loop bound");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> (st_reg == S_IDLE)) else $error("take while busy");
endmodule
`default_nettype wire

[design/float_remainder_binary32.sv]
// top level of the binary32 truncated remainder unit
// special cases take a direct path; otherwise the back loop normalizes subnormal
//   operands, shift-subtracts over the exponent difference and renormalizes
// back end holds one word at a time; a two-entry queue decouples front and back
// reset: rst_n asynchronous active low clears queue and sequencer
`timescale 1ns / 1ps
`default_nettype none
module float_remainder_binary32 import frem_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] dividend_bits,
    input  wire logic [31:0] divisor_bits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      remainder_bits
);
    logic job_valid, job_take;
    job_t job;

    frem_front u_front (.clk, .rst_n, .in_valid, .in_stall, .dividend_bits,
        .divisor_bits, .job_valid, .job_take, .job);
    frem_back u_back (.clk, .rst_n, .job_valid, .job_take, .job, .out_valid,
        .out_stall, .remainder_bits);
endmodule
`default_nettype wire
